// ===== rtl/sacache_pkg.sv =====
// Shared types, sizing constants and helper functions for the set-associative tag cache.
// No dependencies; used by set_assoc_cache_tag_model_unit.
`default_nettype none

package sacache_pkg;

  // Geometry
  localparam int unsigned INDEX_BITS   = 4;
  localparam int unsigned WAYS         = 2;
  localparam int unsigned ADDRESS_BITS = 24;

  // Fixed field widths
  localparam int unsigned ADDR_FIELD_W = 24;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned LFSR_W       = 16;

  // Derived sizes
  localparam int unsigned ADDR_USED_W = (ADDRESS_BITS < ADDR_FIELD_W) ? ADDRESS_BITS
                                                                       : ADDR_FIELD_W;
  localparam int unsigned SETS    = 1 << INDEX_BITS;
  localparam int unsigned TAG_LSB = 2 + INDEX_BITS;
  localparam int unsigned TAG_W   = ADDR_USED_W - TAG_LSB;
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [LFSR_W-1:0]  LFSR_SEED = 16'hACE1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Reciprocal for lfsr mod WAYS: exact for all 16-bit values when WAYS <= 4
  localparam int unsigned RECIP_SH = LFSR_W + 2;
  localparam int unsigned RECIP_W  = RECIP_SH + 1;
  localparam int unsigned PROD_W   = LFSR_W + RECIP_W;
  localparam logic [RECIP_W-1:0] WAY_RECIP = RECIP_W'((2 ** RECIP_SH) / WAYS + 1);

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef logic [TAG_W-1:0] tag_t;
  typedef tag_t [WAYS-1:0]  tag_row_t;

  typedef struct packed {
    logic                    command;
    logic [ADDR_FIELD_W-1:0] address;
  } cache_req_t;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] read_total;
    logic [COUNT_W-1:0] write_total;
    logic [COUNT_W-1:0] hit_total;
    logic [COUNT_W-1:0] miss_total;
  } cache_rsp_t;

  // Fibonacci LFSR x^16+x^14+x^13+x^11+1, shifting right
  function automatic logic [LFSR_W-1:0] lfsr_step(logic [LFSR_W-1:0] l);
    logic fb;
    fb = l[0] ^ l[2] ^ l[3] ^ l[5];
    return {fb, l[LFSR_W-1:1]};
  endfunction

  // Victim way = lfsr mod WAYS, by reciprocal multiply and small correction
  function automatic logic [WAY_W-1:0] lfsr_way(logic [LFSR_W-1:0] l);
    logic [PROD_W-1:0] prod;
    logic [LFSR_W-1:0] quo;
    logic [LFSR_W-1:0] rem;
    prod = PROD_W'(l) * PROD_W'(WAY_RECIP);
    quo  = prod[RECIP_SH +: LFSR_W];
    rem  = l - LFSR_W'(quo * LFSR_W'(WAYS));
    return rem[WAY_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/set_assoc_cache_tag_model_unit.sv =====
// Request and tag row are registered; the compare then loads the output register.
// A new access is taken only once the last is done. The set's row is read, then
// compared and the updated row written back. A finished result waits in the output
// register while the next access is taken; it stalls until that register is free.
// Reset clears valid bits and counters, and loads the LFSR seed. The tag RAM itself
// is not cleared; its entries are gated by the valid bits. Depends on sacache_pkg.
`default_nettype none

module set_assoc_cache_tag_model_unit (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  input  wire sacache_pkg::cache_req_t in_data_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      sacache_pkg::cache_rsp_t out_data_o
);
  import sacache_pkg::*;

  // Tag RAM: one row per set, all ways side by side
  tag_row_t tag_mem [SETS];
  tag_row_t rdata_q;

  logic [SETS-1:0][WAYS-1:0] valid_q, valid_d;
  logic                      busy_q;
  cache_req_t                req_q;
  logic [LFSR_W-1:0]         lfsr_q;
  logic [COUNT_W-1:0]        rd_cnt_q, wr_cnt_q, hit_cnt_q, miss_cnt_q;
  logic [COUNT_W-1:0]        rd_cnt_d, wr_cnt_d, hit_cnt_d, miss_cnt_d;
  logic                      out_valid_q;
  cache_rsp_t                out_q;

  logic                  in_xfer, out_free, done;
  logic [INDEX_BITS-1:0] in_set, set_c;
  tag_t                  tag_c;
  logic [WAY_W-1:0]      way_c;
  logic                  is_write, hit_c, mem_we;
  tag_row_t              row_d;

  // Handshake
  assign in_ready_o  = !busy_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign done        = busy_q && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_set = in_data_i.address[2 +: INDEX_BITS];

  // Decode the held access
  assign set_c    = req_q.address[2 +: INDEX_BITS];
  assign tag_c    = req_q.address[TAG_LSB +: TAG_W];
  assign way_c    = lfsr_way(lfsr_q);
  assign is_write = (req_q.command == CMD_WRITE);

  // Tag compare across the set; a write never looks up
  always_comb begin
    hit_c = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (valid_q[set_c][w] && (rdata_q[w] == tag_c)) hit_c = 1'b1;
    end
    if (is_write) hit_c = 1'b0;
  end

  assign mem_we = done && (is_write || !hit_c);

  // Replacement row and valid update
  always_comb begin
    valid_d = valid_q;
    for (int w = 0; w < WAYS; w++) begin
      row_d[w] = (way_c == WAY_W'(w)) ? tag_c : rdata_q[w];
    end
    if (mem_we) valid_d[set_c][way_c] = 1'b1;
  end

  // Statistics
  always_comb begin
    rd_cnt_d   = rd_cnt_q;
    wr_cnt_d   = wr_cnt_q;
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    if (done) begin
      if (is_write) begin
        wr_cnt_d = sat_inc(wr_cnt_q);
      end else begin
        rd_cnt_d = sat_inc(rd_cnt_q);
        if (hit_c) begin
          hit_cnt_d = sat_inc(hit_cnt_q);
        end else begin
          wr_cnt_d   = sat_inc(wr_cnt_q);
          miss_cnt_d = sat_inc(miss_cnt_q);
        end
      end
    end
  end

  // Tag RAM read port, registered data
  always_ff @(posedge clk_i) begin
    if (in_xfer) rdata_q <= tag_mem[in_set];
  end

  // Tag RAM write port
  always_ff @(posedge clk_i) begin
    if (mem_we) tag_mem[set_c] <= row_d;
  end

  // Request hold register
  always_ff @(posedge clk_i) begin
    if (in_xfer) req_q <= in_data_i;
  end

  // Control, valid bits, counters, LFSR
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      valid_q     <= '0;
      lfsr_q      <= LFSR_SEED;
      rd_cnt_q    <= '0;
      wr_cnt_q    <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) lfsr_q <= lfsr_step(lfsr_q);
      valid_q    <= valid_d;
      rd_cnt_q   <= rd_cnt_d;
      wr_cnt_q   <= wr_cnt_d;
      hit_cnt_q  <= hit_cnt_d;
      miss_cnt_q <= miss_cnt_d;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q.hit         <= hit_c;
      out_q.read_total  <= rd_cnt_d;
      out_q.write_total <= wr_cnt_d;
      out_q.hit_total   <= hit_cnt_d;
      out_q.miss_total  <= miss_cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> busy_q)
    else $error("access accepted but not held for lookup");

  a_done_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (out_valid_q && !busy_q))
    else $error("finished lookup did not load the output register");

  a_lfsr_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0)
    else $error("way picker LFSR locked at zero");

  a_hit_no_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && hit_c) |=> $stable(valid_q))
    else $error("read hit changed valid bits");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for set_assoc_cache_tag_model_unit: a queue-fed driver with bursty
// traffic and a stalling receiver, checked against a tag/valid/counter predictor kept in the TB.
// Depends on sacache_pkg and the RTL of set_assoc_cache_tag_model_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sacache_pkg::*;

  localparam int unsigned ENTRIES    = SETS * WAYS;
  localparam int unsigned N_RANDOM   = 1850;
  localparam int unsigned TAG_POOL_N = 8;

  // Clock, reset and DUT-facing signals; the ones driven by the TB are known from time zero
  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  cache_req_t in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  cache_rsp_t out_data;

  // Pending accesses and predicted results
  cache_req_t access_q[$];
  cache_rsp_t predicted_stats_q[$];
  int unsigned n_sent = 0;
  int unsigned n_err  = 0;

  // Predictor state
  tag_t               tag_mem [ENTRIES];
  logic               tag_vld [ENTRIES];
  logic [COUNT_W-1:0] n_reads, n_writes, n_hits, n_misses;
  logic [LFSR_W-1:0]  victim_lfsr;

  // Receiver hold-off
  logic        hold_off  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_cnt  = 0;

  tag_t tag_pool [TAG_POOL_N];

  set_assoc_cache_tag_model_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial forever #6 clk_i = ~clk_i;

  function automatic logic [COUNT_W-1:0] count_up(logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + COUNT_W'(1);
  endfunction

  // Advance the predicted cache by one access and return the expected statistics
  function automatic cache_rsp_t predict_access(cache_req_t req);
    logic [ADDR_USED_W-1:0] a;
    int unsigned            set_idx;
    int unsigned            vway;
    tag_t                   tg;
    logic                   found;
    cache_rsp_t             rsp;
    a       = req.address[ADDR_USED_W-1:0];
    set_idx = (a >> 2) & (SETS - 1);
    tg      = tag_t'(a >> TAG_LSB);
    vway    = victim_lfsr % WAYS;
    // taps 0, 2, 3, 5 feed the top bit
    victim_lfsr = {^(victim_lfsr & 16'h002D), victim_lfsr[LFSR_W-1:1]};
    found = 1'b0;
    if (req.command == CMD_WRITE) begin
      tag_mem[set_idx * WAYS + vway] = tg;
      tag_vld[set_idx * WAYS + vway] = 1'b1;
      n_writes = count_up(n_writes);
    end else begin
      n_reads = count_up(n_reads);
      for (int w = 0; w < WAYS; w++) begin
        if (tag_vld[set_idx * WAYS + w] && tag_mem[set_idx * WAYS + w] == tg) found = 1'b1;
      end
      if (found) begin
        n_hits = count_up(n_hits);
      end else begin
        tag_mem[set_idx * WAYS + vway] = tg;
        tag_vld[set_idx * WAYS + vway] = 1'b1;
        n_writes = count_up(n_writes);
        n_misses = count_up(n_misses);
      end
    end
    rsp.hit         = found;
    rsp.read_total  = n_reads;
    rsp.write_total = n_writes;
    rsp.hit_total   = n_hits;
    rsp.miss_total  = n_misses;
    return rsp;
  endfunction

  task automatic add_access(logic cmd, logic [ADDR_FIELD_W-1:0] addr);
    cache_req_t r;
    r.command = cmd;
    r.address = addr;
    access_q.push_back(r);
  endtask

  task automatic check_field(string fname, logic [COUNT_W-1:0] exp_v, logic [COUNT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
      n_err++;
    end
  endtask

  // Driver: bursts of random length separated by random gaps; predicts on each transfer
  always @(posedge clk_i or negedge rst_ni) begin : driver
    int unsigned burst_left;
    int unsigned gap_left;
    logic        nxt_valid;
    cache_req_t  nxt_data;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      if (in_valid && in_ready) begin
        predicted_stats_q.push_back(predict_access(in_data));
        n_sent    <= n_sent + 1;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (access_q.size() > 0) begin
          nxt_data  = access_q.pop_front();
          nxt_valid = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            // occasional long unbroken stretch, otherwise short bursts
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  // One long receiver hold-off while the sender keeps offering
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off  <= 1'b0;
      hold_done <= 1'b0;
      hold_cnt  <= 0;
    end else if (!hold_done && !hold_off && n_sent >= 300) begin
      hold_off <= 1'b1;
      hold_cnt <= 0;
    end else if (hold_off) begin
      if (hold_cnt == 200) begin
        hold_off  <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end
  end

  // Receiver stall pattern: mode is picked by the top two bits of a free-running counter
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    logic [8:0] rx_cnt;
    logic       rdy;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_cnt    = '0;
    end else begin
      rx_cnt++;
      case (rx_cnt[8:7])
        2'd0: rdy = 1'b1;
        2'd1: rdy = 1'($urandom_range(0, 1));
        2'd2: rdy = (rx_cnt[1:0] == 2'd0);
        default: rdy = ($urandom_range(0, 9) != 0);
      endcase
      if (hold_off) rdy = 1'b0;
      out_ready <= rdy;
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin : monitor
    cache_rsp_t exp_rsp;
    if (rst_ni && out_valid && out_ready) begin
      if (predicted_stats_q.size() == 0) begin
        $error("result transfer with no prediction pending");
        n_err++;
      end else begin
        exp_rsp = predicted_stats_q.pop_front();
        check_field("hit", COUNT_W'(exp_rsp.hit), COUNT_W'(out_data.hit));
        check_field("read_total", exp_rsp.read_total, out_data.read_total);
        check_field("write_total", exp_rsp.write_total, out_data.write_total);
        check_field("hit_total", exp_rsp.hit_total, out_data.hit_total);
        check_field("miss_total", exp_rsp.miss_total, out_data.miss_total);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    int unsigned r;
    int unsigned set_idx;
    tag_t        tg;
    logic        cmd;
    logic [ADDR_FIELD_W-1:0] addr;

    for (int i = 0; i < ENTRIES; i++) begin
      tag_mem[i] = '0;
      tag_vld[i] = 1'b0;
    end
    n_reads     = '0;
    n_writes    = '0;
    n_hits      = '0;
    n_misses    = '0;
    victim_lfsr = LFSR_SEED;

    // Directed: address extremes, miss then hit, ignored low bits, duplicates, evictions
    add_access(CMD_READ,  24'h000000);
    add_access(CMD_READ,  24'h000000);
    add_access(CMD_READ,  24'h000003);
    add_access(CMD_READ,  24'hFFFFFF);
    add_access(CMD_READ,  24'hFFFFFC);
    add_access(CMD_WRITE, 24'hFFFFFF);
    add_access(CMD_WRITE, 24'h000000);
    add_access(CMD_WRITE, 24'h000000);
    add_access(CMD_READ,  24'h000000);
    add_access(CMD_WRITE, 24'h123454);
    add_access(CMD_WRITE, 24'h123454);
    add_access(CMD_READ,  24'h123454);
    add_access(CMD_READ,  24'h000040);
    add_access(CMD_READ,  24'h000080);
    add_access(CMD_READ,  24'h0000C0);
    add_access(CMD_READ,  24'h000000);
    add_access(CMD_WRITE, 24'h00003C);
    add_access(CMD_READ,  24'h00003C);
    add_access(CMD_READ,  24'hFFFFC0);
    add_access(CMD_READ,  24'h0003FC);

    // Random: mostly a small tag pool, often over few sets, so hits and evictions happen
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < TAG_POOL_N; i++) tag_pool[i] = tag_t'($urandom);
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        tg      = tag_pool[$urandom_range(0, TAG_POOL_N - 1)];
        set_idx = (r < 50) ? $urandom_range(0, 3) : $urandom_range(0, SETS - 1);
        addr    = ADDR_FIELD_W'((ADDR_FIELD_W'(tg) << TAG_LSB) | (set_idx << 2)
                                | $urandom_range(0, 3));
        cmd     = ($urandom_range(0, 9) < 3) ? CMD_WRITE : CMD_READ;
      end else begin
        addr = ADDR_FIELD_W'($urandom);
        cmd  = 1'($urandom_range(0, 1));
      end
      add_access(cmd, addr);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (access_q.size() != 0 || in_valid) @(negedge clk_i);
    while (predicted_stats_q.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);

    if (n_err == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
